FILE: design/isbc_pkg.sv
`default_nettype none

package isbc_pkg;

  // Buffer geometry
  localparam int BUF_DEPTH = 32;
  localparam int ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int IDX_W     = $clog2(BUF_DEPTH + 1);
  localparam int POS_W     = 9;

  typedef enum logic [2:0] {
    CMD_BUS   = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_READ  = 3'd2,
    CMD_SEND  = 3'd3,
    CMD_RECV  = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    BS_RD_ADDR_ACK = 4'd0,
    BS_TX_ACK      = 4'd1,
    BS_TX_NACK     = 4'd2,
    BS_GENCALL     = 4'd3,
    BS_WR_ADDR_ACK = 4'd4,
    BS_RX_ACK      = 4'd5,
    BS_GEN_RX_ACK  = 4'd6,
    BS_STOP        = 4'd7,
    BS_BUS_ERROR   = 4'd8,
    BS_OTHER       = 4'd9
  } bus_status_t;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } fsm_state_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [3:0] bus_status;
    logic [7:0] rx_byte;
    logic [4:0] host_index;
    logic [7:0] host_byte;
    logic [7:0] msg_length;
  } item_t;

  typedef struct packed {
    logic       tx_load;
    logic [7:0] tx_byte;
    logic       int_enable;
    logic       clear_int;
    logic       ack_enable;
    logic       stop_request;
    logic       bus_error_flag;
    logic       last_ok;
    logic       rx_in_buffer;
    logic       general_call;
    logic       read_valid;
    logic [7:0] read_byte;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch item, start buffer read
    logic exec;     // update state, load result register
  } ctl_t;

  // Saturating index step
  function automatic logic [IDX_W-1:0] idx_adv(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] r;
    r = idx;
    if (idx < IDX_W'(BUF_DEPTH)) begin
      r = idx + IDX_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/isbc_ctrl.sv
`default_nettype none

module isbc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output isbc_pkg::ctl_t     ctl
);
  import isbc_pkg::*;

  fsm_state_t state;
  fsm_state_t state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.exec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    ctl.capture = 1'b0;
    ctl.exec    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        ctl.capture = in_valid;
      end
      S_EXEC: begin
        ctl.exec = out_free;
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_EXEC)
    else $error("accepted item did not enter execution");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC && out_valid && !out_ready |=> state == S_EXEC)
    else $error("item left execution while result register was blocked");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (rst)
    ctl.exec |=> out_valid && state == S_IDLE)
    else $error("execution did not produce a result");
`endif

endmodule

`default_nettype wire

FILE: design/isbc_datapath.sv
`default_nettype none

module isbc_datapath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire isbc_pkg::ctl_t   ctl,
  input  wire isbc_pkg::item_t  item_in,
  output isbc_pkg::result_t     res
);
  import isbc_pkg::*;

  // Shared buffer
  logic [7:0] mem [BUF_DEPTH];

  item_t            item;
  logic [7:0]       rd_data;
  logic             rd_oor;

  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic [7:0]       send_length, send_length_next;
  logic             busy, busy_next;
  logic             ok, ok_next;
  logic             pending, pending_next;
  logic             gencall, gencall_next;

  logic [POS_W-1:0] rd_pos;
  logic             mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [7:0]       mem_wd;
  logic [7:0]       rd_val;
  result_t          res_next;

  // Read position chosen from the incoming item and current index
  always_comb begin
    if (item_in.cmd == CMD_BUS && item_in.bus_status == BS_RD_ADDR_ACK) begin
      rd_pos = '0;
    end else if (item_in.cmd == CMD_BUS) begin
      rd_pos = POS_W'(byte_index);
    end else begin
      rd_pos = POS_W'(item_in.host_index);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item    <= item_in;
      rd_data <= mem[rd_pos[ADDR_W-1:0]];
      rd_oor  <= rd_pos >= POS_W'(BUF_DEPTH);
    end
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (ctl.exec) begin
      res <= res_next;
    end
  end

  assign rd_val = rd_oor ? 8'hFF : rd_data;

  always_comb begin
    byte_index_next  = byte_index;
    send_length_next = send_length;
    busy_next        = busy;
    ok_next          = ok;
    pending_next     = pending;
    gencall_next     = gencall;
    mem_we           = 1'b0;
    mem_wa           = byte_index[ADDR_W-1:0];
    mem_wd           = item.rx_byte;
    res_next         = '0;

    if (item.cmd == CMD_BUS) begin
      res_next.clear_int = 1'b1;
      case (item.bus_status) inside
        BS_RD_ADDR_ACK, BS_TX_ACK: begin
          res_next.tx_load    = 1'b1;
          res_next.tx_byte    = rd_val;
          byte_index_next     = (item.bus_status == BS_RD_ADDR_ACK) ?
                                idx_adv('0) : idx_adv(byte_index);
          busy_next           = 1'b1;
          res_next.ack_enable = 1'b1;
        end
        BS_TX_NACK: begin
          if (POS_W'(byte_index) == POS_W'(send_length)) ok_next = 1'b1;
          busy_next          = 1'b0;
          res_next.clear_int = 1'b0;
        end
        BS_GENCALL, BS_WR_ADDR_ACK: begin
          if (item.bus_status == BS_GENCALL) gencall_next = 1'b1;
          pending_next        = 1'b1;
          byte_index_next     = '0;
          busy_next           = 1'b1;
          res_next.ack_enable = 1'b1;
        end
        BS_RX_ACK, BS_GEN_RX_ACK: begin
          mem_we              = ctl.exec && (byte_index < IDX_W'(BUF_DEPTH));
          byte_index_next     = idx_adv(byte_index);
          ok_next             = 1'b1;
          busy_next           = 1'b1;
          res_next.ack_enable = 1'b1;
        end
        BS_STOP: begin
          busy_next          = 1'b0;
          res_next.clear_int = 1'b0;
        end
        default: begin
          // bus error, other and unused codes: recovery with stop
          res_next.bus_error_flag = (item.bus_status == BS_BUS_ERROR);
          busy_next               = 1'b1;
          res_next.ack_enable     = 1'b1;
          res_next.stop_request   = 1'b1;
        end
      endcase
    end else if (!busy) begin
      case (item.cmd) inside
        CMD_WRITE: begin
          mem_we = ctl.exec && (POS_W'(item.host_index) < POS_W'(BUF_DEPTH));
          mem_wa = item.host_index[ADDR_W-1:0];
          mem_wd = item.host_byte;
        end
        CMD_READ: begin
          if (ok) begin
            res_next.read_valid = 1'b1;
            res_next.read_byte  = rd_val;
            pending_next        = 1'b0;
          end
        end
        CMD_SEND, CMD_RECV: begin
          if (item.cmd == CMD_SEND) send_length_next = item.msg_length;
          busy_next           = 1'b1;
          res_next.clear_int  = 1'b1;
          res_next.ack_enable = 1'b1;
        end
        default: ;
      endcase
    end

    res_next.int_enable   = busy_next;
    res_next.last_ok      = ok_next;
    res_next.rx_in_buffer = pending_next;
    res_next.general_call = gencall_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= '0;
      send_length <= '0;
      busy        <= 1'b0;
      ok          <= 1'b0;
      pending     <= 1'b0;
      gencall     <= 1'b0;
    end else if (ctl.exec) begin
      byte_index  <= byte_index_next;
      send_length <= send_length_next;
      busy        <= busy_next;
      ok          <= ok_next;
      pending     <= pending_next;
      gencall     <= gencall_next;
    end
  end

`ifndef SYNTH
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    byte_index <= IDX_W'(BUF_DEPTH))
    else $error("byte index beyond buffer depth");

  a_ok_sticky: assert property (@(posedge clk) disable iff (rst)
    ok |=> ok)
    else $error("transfer ok flag cleared outside reset");

  a_busy_matches_int: assert property (@(posedge clk) disable iff (rst)
    ctl.exec |=> res.int_enable == busy)
    else $error("interrupt enable differs from busy state");
`endif

endmodule

`default_nettype wire

FILE: design/i2c_slave_buffer_controller.sv
`default_nettype none

// Slave-side I2C buffer and sequencer.
// Input channel s_*: one item per bus status event or host command. s_tuser
// carries the command kind, s_tdata the event status, received byte and host
// operands. Output channel m_*: exactly one result item per input item, with
// the control word for the bus interface, the next transmit byte, the status
// flags and host read data; m_tuser flags which of tx_byte / read_byte hold data.
// Each accepted item first has its buffer read registered, then the state update
// loads the result register onto m_*; that update waits while an earlier result
// is still unread. A new item is accepted only once the last one has left execution.
// The next item is accepted while a result still waits on m_*; it then holds in
// execution until m_tready frees the register.
// Reset (rst, synchronous) clears index, send length and all flags and empties
// the result register; buffer contents are undefined until written.
// A stalled receiver holds m_tvalid and the result stable, and stalls at most
// one further item inside the block.

module i2c_slave_buffer_controller (
  input  wire logic        clk,
  input  wire logic        rst,
  // item in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // bus_status[3:0], rx_byte[11:4],
                                     // host_index[16:12], host_byte[24:17],
                                     // msg_length[32:25], zero pad
  input  wire logic [2:0]  s_tuser,  // cmd[2:0]
  // result out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,  // tx_byte[7:0], int_enable[8], clear_int[9],
                                     // ack_enable[10], stop_request[11],
                                     // bus_error_flag[12], last_ok[13],
                                     // rx_in_buffer[14], general_call[15],
                                     // read_byte[23:16]
  output logic [1:0]       m_tuser   // tx_load[0], read_valid[1]
);
  import isbc_pkg::*;

  ctl_t    ctl;
  item_t   item_in;
  result_t res;

  assign item_in.cmd        = s_tuser;
  assign item_in.bus_status = s_tdata[3:0];
  assign item_in.rx_byte    = s_tdata[11:4];
  assign item_in.host_index = s_tdata[16:12];
  assign item_in.host_byte  = s_tdata[24:17];
  assign item_in.msg_length = s_tdata[32:25];

  isbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .ctl       (ctl)
  );

  isbc_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .item_in (item_in),
    .res     (res)
  );

  // Result packing
  assign m_tdata = {res.read_byte, res.general_call, res.rx_in_buffer, res.last_ok,
                    res.bus_error_flag, res.stop_request, res.ack_enable,
                    res.clear_int, res.int_enable, res.tx_byte};
  assign m_tuser = {res.read_valid, res.tx_load};

endmodule

`default_nettype wire

FILE: bench/i2c_slave_buffer_controller_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the I2C slave buffer controller.
// The buffer is filled by host writes right after reset, so every later read
// within it (transmit or host read) hits a written entry. Then a short directed run
// covers each command and bus status, followed by random master read/write
// transactions, host buffer traffic and noise. Every accepted item runs
// through a local model of the sequencer; its result is queued and compared
// against the block's output in order.

module i2c_slave_buffer_controller_tb;
  import isbc_pkg::*;

  localparam int  N_RANDOM      = 1900;
  localparam int  HOLD_AFTER    = 400;  // results seen before the long hold-off
  localparam int  HOLD_CYCLES   = 300;
  localparam int  MAX_REPORTS   = 10;
  // top of the 4-bit status space, not a defined status
  localparam logic [3:0] BS_UNUSED_TOP = 4'hF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;

  always #4 clk = ~clk;

  i2c_slave_buffer_controller DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // ---------------------------------------------------------------------------
  // Sequencer model: buffer, index, send length and flags
  // ---------------------------------------------------------------------------
  logic [7:0] shadow_buf [BUF_DEPTH];
  logic [5:0] shadow_idx;     // 0..BUF_DEPTH, saturating
  logic [7:0] shadow_len;
  logic       shadow_busy;
  logic       shadow_ok;
  logic       shadow_pend;
  logic       shadow_gc;

  // positions past the buffer read back as all ones
  function automatic logic [7:0] buf_at(logic [5:0] pos);
    return (pos < BUF_DEPTH) ? shadow_buf[pos[4:0]] : 8'hFF;
  endfunction

  function automatic void idx_step();
    if (shadow_idx < BUF_DEPTH) shadow_idx = shadow_idx + 6'd1;
  endfunction

  function automatic result_t sequencer_step(item_t it);
    result_t r;
    r = '0;
    if (it.cmd == CMD_BUS) begin
      r.clear_int = 1'b1;
      case (it.bus_status) inside
        BS_RD_ADDR_ACK, BS_TX_ACK: begin
          if (it.bus_status == BS_RD_ADDR_ACK) shadow_idx = '0;
          r.tx_load = 1'b1;
          r.tx_byte = buf_at(shadow_idx);
          idx_step();
          shadow_busy = 1'b1;
          r.ack_enable = 1'b1;
        end
        BS_TX_NACK: begin
          // good transfer only when the whole armed length went out
          if ({2'b00, shadow_idx} == shadow_len) shadow_ok = 1'b1;
          shadow_busy = 1'b0;
          r.clear_int = 1'b0;
        end
        BS_GENCALL, BS_WR_ADDR_ACK: begin
          if (it.bus_status == BS_GENCALL) shadow_gc = 1'b1;
          shadow_pend = 1'b1;
          shadow_idx = '0;
          shadow_busy = 1'b1;
          r.ack_enable = 1'b1;
        end
        BS_RX_ACK, BS_GEN_RX_ACK: begin
          // bytes past the buffer end are dropped
          if (shadow_idx < BUF_DEPTH) shadow_buf[shadow_idx[4:0]] = it.rx_byte;
          idx_step();
          shadow_ok = 1'b1;
          shadow_busy = 1'b1;
          r.ack_enable = 1'b1;
        end
        BS_STOP: begin
          shadow_busy = 1'b0;
          r.clear_int = 1'b0;
        end
        default: begin
          // bus error, other and unused codes: recovery with stop
          r.bus_error_flag = (it.bus_status == BS_BUS_ERROR);
          shadow_busy = 1'b1;
          r.ack_enable = 1'b1;
          r.stop_request = 1'b1;
        end
      endcase
    end else if (!shadow_busy) begin
      // host side commands only while the bus side is idle
      case (it.cmd) inside
        CMD_WRITE: shadow_buf[it.host_index] = it.host_byte;
        CMD_READ: begin
          if (shadow_ok) begin
            r.read_valid = 1'b1;
            r.read_byte = buf_at({1'b0, it.host_index});
            shadow_pend = 1'b0;
          end
        end
        CMD_SEND, CMD_RECV: begin
          if (it.cmd == CMD_SEND) shadow_len = it.msg_length;
          shadow_busy = 1'b1;
          r.clear_int = 1'b1;
          r.ack_enable = 1'b1;
        end
        default: ;
      endcase
    end
    r.int_enable = shadow_busy;
    r.last_ok = shadow_ok;
    r.rx_in_buffer = shadow_pend;
    r.general_call = shadow_gc;
    return r;
  endfunction

  function automatic string result_str(result_t r);
    return $sformatf({"txl=%0d txb=%02h ie=%0d clr=%0d ack=%0d stop=%0d berr=%0d ",
                      "ok=%0d pend=%0d gc=%0d rv=%0d rb=%02h"},
                     r.tx_load, r.tx_byte, r.int_enable, r.clear_int, r.ack_enable,
                     r.stop_request, r.bus_error_flag, r.last_ok, r.rx_in_buffer,
                     r.general_call, r.read_valid, r.read_byte);
  endfunction

  // ---------------------------------------------------------------------------
  // Item generation
  // ---------------------------------------------------------------------------
  item_t   stim_items[$];
  result_t expected_results[$];

  // all operand fields random, so every bit toggles on unused fields too
  function automatic item_t rand_item(logic [2:0] c, logic [3:0] st);
    item_t it;
    it.cmd = c;
    it.bus_status = st;
    it.rx_byte = 8'($urandom);
    it.host_index = 5'($urandom);
    it.host_byte = 8'($urandom);
    it.msg_length = 8'($urandom);
    return it;
  endfunction

  task automatic add_event(logic [3:0] st);
    stim_items.push_back(rand_item(CMD_BUS, st));
  endtask

  // master reads from us: arm, address, n_acks more bytes, final nack
  task automatic add_master_read(int len, int n_acks);
    item_t it;
    it = rand_item(CMD_SEND, BS_OTHER);
    it.msg_length = 8'(len);
    stim_items.push_back(it);
    add_event(BS_RD_ADDR_ACK);
    repeat (n_acks) add_event(BS_TX_ACK);
    add_event(BS_TX_NACK);
  endtask

  // master writes to us: optional arm, address or general call, data, stop
  task automatic add_master_write(bit gen, int n_bytes);
    if ($urandom_range(0, 4) != 0) stim_items.push_back(rand_item(CMD_RECV, BS_OTHER));
    add_event(gen ? BS_GENCALL : BS_WR_ADDR_ACK);
    repeat (n_bytes) add_event($urandom_range(0, 1) ? BS_RX_ACK : BS_GEN_RX_ACK);
    add_event(BS_STOP);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one item in flight on s_*, random gap before each new item
  // ---------------------------------------------------------------------------
  item_t cur_item;
  int    gap_left = 0;
  bit    send_burst = 1'b0;
  bit    offer_free;
  int    n_accepted = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      offer_free = !s_tvalid || s_tready;
      if (s_tvalid && s_tready) begin
        expected_results.push_back(sequencer_step(cur_item));
        n_accepted++;
      end
      if (offer_free) begin
        if (gap_left > 0 || stim_items.size() == 0) begin
          if (gap_left > 0) gap_left--;
          s_tvalid <= 1'b0;
        end else begin
          cur_item = stim_items.pop_front();
          s_tuser <= cur_item.cmd;
          s_tdata <= {7'b0, cur_item.msg_length, cur_item.host_byte, cur_item.host_index,
                      cur_item.rx_byte, cur_item.bus_status};
          s_tvalid <= 1'b1;
          // occasionally switch between gapped and back-to-back stretches
          if ($urandom_range(0, 149) == 0) send_burst = !send_burst;
          gap_left = send_burst ? 0 : $urandom_range(0, 6);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result, draws a stall after each one
  // ---------------------------------------------------------------------------
  logic    hold_off;
  int      stall_left = 0;
  bit      recv_burst = 1'b0;
  int      n_results = 0;
  int      n_errors = 0;
  int      n_tx_loads = 0;
  int      n_reads = 0;
  int      n_bus_errs = 0;
  result_t got, want;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.tx_load        = m_tuser[0];
        got.tx_byte        = m_tdata[7:0];
        got.int_enable     = m_tdata[8];
        got.clear_int      = m_tdata[9];
        got.ack_enable     = m_tdata[10];
        got.stop_request   = m_tdata[11];
        got.bus_error_flag = m_tdata[12];
        got.last_ok        = m_tdata[13];
        got.rx_in_buffer   = m_tdata[14];
        got.general_call   = m_tdata[15];
        got.read_valid     = m_tuser[1];
        got.read_byte      = m_tdata[23:16];
        if (expected_results.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("[%0t] result %0d arrived with nothing expected: %s",
                     $time, n_results, result_str(got));
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS) begin
              $display("[%0t] result %0d mismatch", $time, n_results);
              $display("  expected %s", result_str(want));
              $display("  actual   %s", result_str(got));
            end
          end
          if (want.tx_load) n_tx_loads++;
          if (want.read_valid) n_reads++;
          if (want.bus_error_flag) n_bus_errs++;
        end
        n_results <= n_results + 1;
        if ($urandom_range(0, 149) == 0) recv_burst = !recv_burst;
        stall_left = recv_burst ? 0 : $urandom_range(0, 6);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      m_tready <= (stall_left == 0) && !hold_off;
    end
  end

  // ---------------------------------------------------------------------------
  // Long receiver hold-off: output backs up and the input must stall
  // ---------------------------------------------------------------------------
  int hold_cnt = 0;
  int n_input_stalls = 0;

  always @(posedge clk) begin
    if (rst) begin
      hold_off <= 1'b0;
      hold_cnt = 0;
    end else if (n_results >= HOLD_AFTER && hold_cnt < HOLD_CYCLES) begin
      hold_off <= 1'b1;
      hold_cnt++;
      if (s_tvalid && !s_tready) n_input_stalls++;
    end else begin
      hold_off <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    item_t it;
    int    pick;
    int    len;
    int    n_acks;
    int    n_total;

    shadow_idx = '0;
    shadow_len = '0;
    shadow_busy = 1'b0;
    shadow_ok = 1'b0;
    shadow_pend = 1'b0;
    shadow_gc = 1'b0;

    // preload the whole buffer from the host side; ends at 00 and FF
    for (int i = 0; i < BUF_DEPTH; i++) begin
      it = rand_item(CMD_WRITE, BS_OTHER);
      it.host_index = 5'(i);
      if (i == 0) it.host_byte = 8'h00;
      if (i == BUF_DEPTH - 1) it.host_byte = 8'hFF;
      stim_items.push_back(it);
    end

    // directed: host read before any good transfer is ignored
    it = rand_item(CMD_READ, BS_OTHER);
    it.host_index = 5'd0;
    stim_items.push_back(it);
    // undefined commands do nothing
    for (int c = int'(CMD_RECV) + 1; c < 8; c++) stim_items.push_back(rand_item(3'(c), BS_OTHER));
    // two-byte master read, with a host write while busy in the middle
    it = rand_item(CMD_SEND, BS_OTHER);
    it.msg_length = 8'd2;
    stim_items.push_back(it);
    it = rand_item(CMD_WRITE, BS_OTHER);
    it.host_index = 5'd31;
    it.host_byte = 8'h00;
    stim_items.push_back(it);
    add_event(BS_RD_ADDR_ACK);
    add_event(BS_TX_ACK);
    add_event(BS_TX_NACK);
    it = rand_item(CMD_READ, BS_OTHER);
    it.host_index = 5'd31;
    stim_items.push_back(it);
    // general-call write with extreme data bytes
    stim_items.push_back(rand_item(CMD_RECV, BS_OTHER));
    add_event(BS_GENCALL);
    it = rand_item(CMD_BUS, BS_GEN_RX_ACK);
    it.rx_byte = 8'h00;
    stim_items.push_back(it);
    it = rand_item(CMD_BUS, BS_RX_ACK);
    it.rx_byte = 8'hFF;
    stim_items.push_back(it);
    add_event(BS_STOP);
    // valid host read clears the data-waiting flag
    it = rand_item(CMD_READ, BS_OTHER);
    it.host_index = 5'd0;
    stim_items.push_back(it);
    // recovery paths: bus error, other, undefined status
    add_event(BS_BUS_ERROR);
    add_event(BS_STOP);
    add_event(BS_OTHER);
    add_event(BS_UNUSED_TOP);
    add_event(BS_STOP);
    // send length far beyond the buffer, then a plain write address
    add_master_read(255, 0);
    add_event(BS_WR_ADDR_ACK);
    add_event(BS_STOP);

    n_total = stim_items.size() + N_RANDOM;
    while (stim_items.size() < n_total) begin
      pick = $urandom_range(0, 19);
      if (pick < 6) begin
        pick = $urandom_range(0, 19);
        if (pick < 15) len = $urandom_range(1, 8);
        else if (pick < 18) len = $urandom_range(9, 40);
        else len = $urandom_range(0, 255);
        // mostly the exact byte count, so transfers up to the buffer depth are marked good
        if ($urandom_range(0, 9) < 7 && len >= 1 && len <= 41) n_acks = len - 1;
        else n_acks = $urandom_range(0, 12);
        add_master_read(len, n_acks);
      end else if (pick < 12) begin
        // some writes run past the buffer end
        add_master_write($urandom_range(0, 3) == 0,
                         ($urandom_range(0, 4) == 0) ? $urandom_range(30, 40)
                                                     : $urandom_range(0, 8));
      end else if (pick < 16) begin
        repeat ($urandom_range(1, 6))
          stim_items.push_back(rand_item($urandom_range(0, 1) ? CMD_WRITE : CMD_READ,
                                         BS_OTHER));
      end else begin
        repeat ($urandom_range(1, 4))
          stim_items.push_back(rand_item(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15))));
        if ($urandom_range(0, 4) != 0) add_event(BS_STOP);
      end
    end
    n_total = stim_items.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (n_accepted != n_total || expected_results.size() != 0);
    repeat (10) @(negedge clk);

    $display("covered %0d items: %0d transmit loads, %0d valid host reads, %0d bus errors",
             n_results, n_tx_loads, n_reads, n_bus_errs);
    $display("input held off for %0d cycles during the long output stall", n_input_stalls);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total", n_errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #3000000;
    $display("timeout: %0d items accepted, %0d results pending",
             n_accepted, expected_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: filelist.f
design/isbc_pkg.sv
design/isbc_ctrl.sv
design/isbc_datapath.sv
design/i2c_slave_buffer_controller.sv
bench/i2c_slave_buffer_controller_tb.sv
